// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions on the rising clock edge.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset
`define YRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included
`define YRF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/yrf_pkg.sv
// ----------------------------------------------------------------------------
// yrf_pkg
// Frame geometry, fixed-point coefficients and shared types of the converter.
// ----------------------------------------------------------------------------
package yrf_pkg;

    localparam int PAIRS_PER_LINE = 320;
    localparam int LINES          = 480;

    localparam int SAMPLE_W = 8;
    localparam int ADDR_W   = 18;
    localparam int COL_W    = (PAIRS_PER_LINE > 1) ? $clog2(PAIRS_PER_LINE) : 1;
    localparam int ROW_W    = (LINES > 1) ? $clog2(LINES) : 1;

    // Q14 accumulator: luma term plus one or two products, with headroom
    localparam int FRAC_BITS = 14;
    localparam int ACC_W     = 25;

    localparam logic signed [ACC_W-1:0] COEF_RV = ACC_W'(22970);
    localparam logic signed [ACC_W-1:0] COEF_GU = ACC_W'(5638);
    localparam logic signed [ACC_W-1:0] COEF_GV = ACC_W'(11700);
    localparam logic signed [ACC_W-1:0] COEF_BU = ACC_W'(29032);

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(PAIRS_PER_LINE - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(LINES - 1);
    localparam logic [ADDR_W-1:0] ADDR_BASE = ADDR_W'((LINES - 1) * PAIRS_PER_LINE);
    localparam logic [ADDR_W-1:0] ROW_BACK  = ADDR_W'(2 * PAIRS_PER_LINE - 1);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAIRS_PER_LINE - 1);

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_pos;

    // Floor shift by FRAC_BITS, then clamp to 0..255
    function automatic logic [SAMPLE_W-1:0] sat8(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_BITS-1:0] q;
        q = acc[ACC_W-1:FRAC_BITS];
        if (q[ACC_W-FRAC_BITS-1]) begin
            sat8 = '0;
        end else if (|q[ACC_W-FRAC_BITS-2:SAMPLE_W]) begin
            sat8 = '1;
        end else begin
            sat8 = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

// File: src/yrf_if.sv
// ----------------------------------------------------------------------------
// yrf channel interfaces
// Valid/ready channels for packed YUYV pairs in and BGR pairs out.
// ----------------------------------------------------------------------------
interface yrf_yuyv_if;
    import yrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] luma_first;
    logic [SAMPLE_W-1:0] chroma_blue;
    logic [SAMPLE_W-1:0] luma_second;
    logic [SAMPLE_W-1:0] chroma_red;

    modport source (output valid, luma_first, chroma_blue, luma_second, chroma_red,
                    input ready);
    modport sink (input valid, luma_first, chroma_blue, luma_second, chroma_red,
                  output ready);
endinterface

interface yrf_rgb_if;
    import yrf_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] blue_a;
    logic [SAMPLE_W-1:0] green_a;
    logic [SAMPLE_W-1:0] red_a;
    logic [SAMPLE_W-1:0] blue_b;
    logic [SAMPLE_W-1:0] green_b;
    logic [SAMPLE_W-1:0] red_b;
    logic [ADDR_W-1:0]   pair_address;
    logic                frame_end;

    modport source (output valid, blue_a, green_a, red_a, blue_b, green_b, red_b,
                    pair_address, frame_end, input ready);
    modport sink (input valid, blue_a, green_a, red_a, blue_b, green_b, red_b,
                  pair_address, frame_end, output ready);
endinterface

// File: src/yrf_addr_gen.sv
// ----------------------------------------------------------------------------
// yrf_addr_gen
// Column and row counters over the frame, and the running bottom-up address.
// ----------------------------------------------------------------------------
module yrf_addr_gen (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_advance,
    output yrf_pkg::t_pos o_pos
);
    import yrf_pkg::*;

    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              last_col;
    logic              last_row;

    assign last_col = (r_col == LAST_COL);
    assign last_row = (r_row == LAST_ROW);

    // Address rises by one in a line, then drops to the previous line's start
    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_addr = r_addr;
        if (i_advance) begin
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row  = '0;
                    n_addr = ADDR_BASE;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_addr = r_addr - ROW_BACK;
                end
            end else begin
                n_col  = r_col + 1'b1;
                n_addr = r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_addr <= ADDR_BASE;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_addr <= n_addr;
        end
    end

    assign o_pos.addr = r_addr;
    assign o_pos.last = last_col && last_row;

endmodule

// File: src/yuyv_to_rgb_flip_converter.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_flip_converter
// YUYV 4:2:2 pairs to BGR888 pairs (BT.601 full range), bottom-up addressing.
// ----------------------------------------------------------------------------
// Takes one YUYV pair per clock and returns one BGR pair per clock while the
// output is not stalled. A result passes through four register stages: input
// register, coefficient multipliers, adders, then the green subtract with
// saturation into the output register. Each
// stage moves whenever the one after it is empty or moving, so bubbles close
// up and the input stays ready as long as the output register is free. The
// pair address counts BMP-style from the bottom line up; frame_end marks the
// last pair of a frame, and only reset realigns the frame counters.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_flip_converter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    yrf_yuyv_if.sink  i_pair,
    yrf_rgb_if.source o_rgb
);
    import yrf_pkg::*;

    logic adv1, adv2, adv3, adv4;
    logic r_v1, r_v2, r_v3, r_v4;
    logic in_accept;
    t_pos pos;

    // Stage 1: captured samples, chroma with its offset removed
    logic [SAMPLE_W-1:0]        r_s1_y0, r_s1_y1;
    logic signed [SAMPLE_W-1:0] r_s1_du, r_s1_dv;
    t_pos                       r_s1_pos;
    // Stage 2: products
    logic [SAMPLE_W-1:0]        r_s2_y0, r_s2_y1;
    logic signed [ACC_W-1:0]    r_s2_bu, r_s2_gu, r_s2_gv, r_s2_rv;
    t_pos                       r_s2_pos;
    // Stage 3: sums
    logic signed [ACC_W-1:0]    r_s3_b0, r_s3_b1, r_s3_r0, r_s3_r1;
    logic signed [ACC_W-1:0]    r_s3_base0, r_s3_base1, r_s3_guv;
    t_pos                       r_s3_pos;
    // Stage 4: output register
    logic [SAMPLE_W-1:0]        r_s4_b0, r_s4_g0, r_s4_r0, r_s4_b1, r_s4_g1, r_s4_r1;
    t_pos                       r_s4_pos;

    logic signed [ACC_W-1:0] du_w, dv_w, base0, base1;

    assign adv4 = !r_v4 || o_rgb.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_pair.ready = adv1;
    assign in_accept    = i_pair.valid && adv1;

    yrf_addr_gen u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (in_accept),
        .o_pos     (pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_pair.valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv4) r_v4 <= r_v3;
        end
    end

    assign du_w  = ACC_W'(r_s1_du);
    assign dv_w  = ACC_W'(r_s1_dv);
    assign base0 = {{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, r_s2_y0, {FRAC_BITS{1'b0}}};
    assign base1 = {{(ACC_W-SAMPLE_W-FRAC_BITS){1'b0}}, r_s2_y1, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_y0  <= i_pair.luma_first;
            r_s1_y1  <= i_pair.luma_second;
            // Flip the top bit to take 128 off
            r_s1_du  <= {~i_pair.chroma_blue[SAMPLE_W-1], i_pair.chroma_blue[SAMPLE_W-2:0]};
            r_s1_dv  <= {~i_pair.chroma_red[SAMPLE_W-1], i_pair.chroma_red[SAMPLE_W-2:0]};
            r_s1_pos <= pos;
        end
        if (adv2) begin
            r_s2_y0  <= r_s1_y0;
            r_s2_y1  <= r_s1_y1;
            r_s2_bu  <= COEF_BU * du_w;
            r_s2_gu  <= COEF_GU * du_w;
            r_s2_gv  <= COEF_GV * dv_w;
            r_s2_rv  <= COEF_RV * dv_w;
            r_s2_pos <= r_s1_pos;
        end
        if (adv3) begin
            r_s3_b0    <= base0 + r_s2_bu;
            r_s3_b1    <= base1 + r_s2_bu;
            r_s3_r0    <= base0 + r_s2_rv;
            r_s3_r1    <= base1 + r_s2_rv;
            r_s3_guv   <= r_s2_gu + r_s2_gv;
            r_s3_base0 <= base0;
            r_s3_base1 <= base1;
            r_s3_pos   <= r_s2_pos;
        end
        if (adv4) begin
            r_s4_b0  <= sat8(r_s3_b0);
            r_s4_r0  <= sat8(r_s3_r0);
            r_s4_g0  <= sat8(r_s3_base0 - r_s3_guv);
            r_s4_b1  <= sat8(r_s3_b1);
            r_s4_r1  <= sat8(r_s3_r1);
            r_s4_g1  <= sat8(r_s3_base1 - r_s3_guv);
            r_s4_pos <= r_s3_pos;
        end
    end

    assign o_rgb.valid        = r_v4;
    assign o_rgb.blue_a       = r_s4_b0;
    assign o_rgb.green_a      = r_s4_g0;
    assign o_rgb.red_a        = r_s4_r0;
    assign o_rgb.blue_b       = r_s4_b1;
    assign o_rgb.green_b      = r_s4_g1;
    assign o_rgb.red_b        = r_s4_r1;
    assign o_rgb.pair_address = r_s4_pos.addr;
    assign o_rgb.frame_end    = r_s4_pos.last;

endmodule

// File: src/yrf_checker.sv
// ----------------------------------------------------------------------------
// yrf_checker
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yrf_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [yrf_pkg::ADDR_W-1:0]   i_addr,
    input logic                         i_last,
    input logic [yrf_pkg::SAMPLE_W-1:0] i_red_a
);
    import yrf_pkg::*;

    // A stalled result holds its payload
    `YRF_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_addr) && $stable(i_last) && $stable(i_red_a), "stalled result changed")

    // Reset empties the pipeline
    `YRF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A free output register means every stage can advance
    `YRF_ASSERT(a_ready_when_free, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with output free")

    // The last pair of a frame sits on the first line in memory at its last column
    `YRF_ASSERT(a_frame_end_addr, i_clk, i_rst_n, i_out_valid && i_last |-> i_addr == LAST_ADDR, "frame end at wrong address")

endmodule

bind yuyv_to_rgb_flip_converter yrf_checker u_yrf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pair.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_addr      (o_rgb.pair_address),
    .i_last      (o_rgb.frame_end),
    .i_red_a     (o_rgb.red_a)
);
